### hdl/hrfe_pkg.sv
// ----------------------------------------------------------------------------
// hrfe_pkg
// Shared types, constants and helpers of the response header field encoder.
// ----------------------------------------------------------------------------
package hrfe_pkg;

  // most decimal digits a value may have (3 to 10)
  localparam int MAX_DIGITS = 10;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);

  // depth of the queue between front and back
  localparam int QDEPTH = 2;
  localparam int QIDX_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // header bytes
  localparam logic [7:0] HDR_INDEXED    = 8'h80;
  localparam logic [7:0] HDR_STATUS_LIT = 8'h08;
  localparam logic [7:0] HDR_INC_INDEX  = 8'h40;
  localparam logic [7:0] CLEN_NAME_IDX  = 8'd28;
  localparam logic [7:0] HDR_CLEN_LIT   = HDR_INC_INDEX | CLEN_NAME_IDX;
  localparam logic [7:0] ASCII_ZERO     = 8'h30;

  // request kinds
  typedef enum logic {
    REQ_STATUS = 1'b0,
    REQ_CLEN   = 1'b1
  } req_kind_e;

  // static table indexes of the common status codes
  localparam logic [3:0] SIDX_NONE = 4'd0;
  localparam logic [3:0] SIDX_200  = 4'd8;
  localparam logic [3:0] SIDX_204  = 4'd9;
  localparam logic [3:0] SIDX_206  = 4'd10;
  localparam logic [3:0] SIDX_304  = 4'd11;
  localparam logic [3:0] SIDX_400  = 4'd12;
  localparam logic [3:0] SIDX_404  = 4'd13;
  localparam logic [3:0] SIDX_500  = 4'd14;

  // reciprocal of ten, exact for values below 2^32 with a shift of 35
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // largest value with MAX_DIGITS decimal digits
  function automatic logic [63:0] sat_limit();
    logic [63:0] lim;
    lim = 64'd1;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      lim = lim * 64'd10;
    end
    return lim - 64'd1;
  endfunction

  localparam logic [63:0] SAT_LIMIT = sat_limit();

  // status code to static table index, none for other codes
  function automatic logic [3:0] status_index(input logic [30:0] code);
    logic [3:0] idx;
    unique case (code)
      31'd200: idx = SIDX_200;
      31'd204: idx = SIDX_204;
      31'd206: idx = SIDX_206;
      31'd304: idx = SIDX_304;
      31'd400: idx = SIDX_400;
      31'd404: idx = SIDX_404;
      31'd500: idx = SIDX_500;
      default: idx = SIDX_NONE;
    endcase
    return idx;
  endfunction

  // request and result payloads
  typedef struct packed {
    logic        req_type;
    logic [30:0] number;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } res_t;

  // one classified field waiting for the back end; digits stored lsd first
  typedef struct packed {
    logic                        indexed;
    logic [7:0]                  hdr;
    logic [CNT_W-1:0]            ndig;
    logic [MAX_DIGITS-1:0][3:0]  digits;
  } entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } fe_state_e;

  typedef enum logic [1:0] {
    BK_HDR,
    BK_LEN,
    BK_DIG
  } bk_state_e;

endpackage

### hdl/hrfe_front.sv
// ----------------------------------------------------------------------------
// hrfe_front
// Takes requests, classifies them and turns literal values into decimal
// digits, one digit per cycle, then hands the field to the queue.
// ----------------------------------------------------------------------------
module hrfe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  hrfe_pkg::req_t      req_i,
  input  hrfe_pkg::fifo_stat_t stat_i,
  output logic                push_o,
  output hrfe_pkg::entry_t    entry_o
);
  import hrfe_pkg::*;

  fe_state_e   state_q, state_d;
  entry_t      entry_q, entry_d;
  logic [30:0] val_q, val_d;

  logic        ready;
  logic        accept;
  logic [3:0]  sidx;
  logic [30:0] sat_val;
  logic [63:0] prod;
  logic [30:0] quot;
  logic [30:0] quot10;
  logic [3:0]  rem;
  logic        conv_done;

  // divide by ten through the reciprocal
  always_comb begin
    prod      = 64'({33'd0, val_q} * {32'd0, RECIP10});
    quot      = 31'(prod >> RECIP_SHIFT);
    quot10    = (quot << 3) + (quot << 1);
    rem       = 4'(val_q - quot10);
    conv_done = (quot == 31'd0) || (entry_q.ndig == CNT_W'(MAX_DIGITS - 1));
  end

  // classification of the incoming request
  always_comb begin
    sidx    = status_index(req_i.number);
    sat_val = ({33'd0, req_i.number} > SAT_LIMIT) ? 31'(SAT_LIMIT) : req_i.number;
  end

  assign ready   = (state_q == FE_IDLE) || ((state_q == FE_PUSH) && !stat_i.full);
  assign accept  = start && ready;
  assign busy    = !ready;
  assign push_o  = (state_q == FE_PUSH) && !stat_i.full;
  assign entry_o = entry_q;

  // next state and working registers
  always_comb begin
    state_d = state_q;
    entry_d = entry_q;
    val_d   = val_q;
    unique case (state_q)
      FE_IDLE, FE_PUSH: begin
        if (push_o) begin
          state_d = FE_IDLE;
        end
        if (accept) begin
          entry_d.ndig = '0;
          if ((req_i.req_type == REQ_STATUS) && (sidx != SIDX_NONE)) begin
            entry_d.indexed = 1'b1;
            entry_d.hdr     = HDR_INDEXED | {4'd0, sidx};
            state_d         = FE_PUSH;
          end else begin
            entry_d.indexed = 1'b0;
            entry_d.hdr     = (req_i.req_type == REQ_CLEN) ? HDR_CLEN_LIT : HDR_STATUS_LIT;
            val_d           = sat_val;
            state_d         = FE_CONV;
          end
        end
      end
      FE_CONV: begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
          if (CNT_W'(i) == entry_q.ndig) begin
            entry_d.digits[i] = rem;
          end
        end
        entry_d.ndig = entry_q.ndig + CNT_W'(1);
        val_d        = quot;
        if (conv_done) begin
          state_d = FE_PUSH;
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    val_q   <= val_d;
  end

endmodule

### hdl/hrfe_fifo.sv
// ----------------------------------------------------------------------------
// hrfe_fifo
// Short queue of classified fields between the front and the back end.
// ----------------------------------------------------------------------------
module hrfe_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  hrfe_pkg::entry_t     wdata_i,
  input  logic                 pop_i,
  output hrfe_pkg::entry_t     rdata_o,
  output hrfe_pkg::fifo_stat_t stat_o
);
  import hrfe_pkg::*;

  entry_t            mem_q [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QIDX_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QIDX_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QIDX_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QIDX_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QIDX_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### hdl/hrfe_back.sv
// ----------------------------------------------------------------------------
// hrfe_back
// Walks the head-of-queue field, one byte per cycle while the queue holds one:
// header byte, then for literals length byte and ASCII digits msd first.
// ----------------------------------------------------------------------------
module hrfe_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hrfe_pkg::entry_t     head_i,
  input  hrfe_pkg::fifo_stat_t stat_i,
  output logic                 pop_o,
  output logic                 valid_o,
  output hrfe_pkg::res_t       res_o
);
  import hrfe_pkg::*;

  bk_state_e          state_q, state_d;
  logic [DIG_IDX_W-1:0] didx_q, didx_d;
  logic               valid_q, valid_d;
  res_t               res_q, res_d;

  // byte sequencing
  always_comb begin
    state_d = state_q;
    didx_d  = didx_q;
    valid_d = 1'b0;
    res_d   = res_q;
    pop_o   = 1'b0;
    if (!stat_i.empty) begin
      valid_d = 1'b1;
      unique case (state_q)
        BK_HDR: begin
          res_d.out_byte = head_i.hdr;
          res_d.last     = head_i.indexed;
          if (head_i.indexed) begin
            pop_o = 1'b1;
          end else begin
            state_d = BK_LEN;
          end
        end
        BK_LEN: begin
          res_d.out_byte = 8'(head_i.ndig);
          res_d.last     = 1'b0;
          didx_d         = DIG_IDX_W'(head_i.ndig - CNT_W'(1));
          state_d        = BK_DIG;
        end
        BK_DIG: begin
          res_d.out_byte = ASCII_ZERO | {4'd0, head_i.digits[didx_q]};
          res_d.last     = (didx_q == '0);
          if (didx_q == '0) begin
            pop_o   = 1'b1;
            state_d = BK_HDR;
          end else begin
            didx_d = didx_q - DIG_IDX_W'(1);
          end
        end
        default: state_d = BK_HDR;
      endcase
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_HDR;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // output byte and digit pointer
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    didx_q <= didx_d;
  end

endmodule

### hdl/http_response_field_encoder.sv
// ----------------------------------------------------------------------------
// http_response_field_encoder
// Encodes one compressed response header field (status code or content
// length) per request and streams it out a byte at a time.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Common status codes
// give one indexed byte; other status codes and content lengths give a
// header byte, a length byte and n decimal digits, so n + 2 bytes. Bytes
// leave one per cycle on res_o with valid_o high for one cycle each, and the
// receiver cannot stall them; last marks the final byte of a field. The
// front end turns a value into digits at one digit per cycle through a
// reciprocal multiplier; the output port, at one byte per cycle, limits
// the sustained field rate. A two-entry queue lets the next request be
// converted while the previous field is still being sent. When the queue
// is empty, a field passes the front end's entry register, the queue and
// the back end's output register before its first byte appears.
// ----------------------------------------------------------------------------
module http_response_field_encoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  hrfe_pkg::req_t req_i,
  output logic           valid_o,
  output hrfe_pkg::res_t res_o
);
  import hrfe_pkg::*;

  logic       push;
  logic       pop;
  entry_t     wr_entry;
  entry_t     head;
  fifo_stat_t stat;

  hrfe_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .stat_i  (stat),
    .push_o  (push),
    .entry_o (wr_entry)
  );

  hrfe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_entry),
    .pop_i   (pop),
    .rdata_o (head),
    .stat_o  (stat)
  );

  hrfe_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .stat_i  (stat),
    .pop_o   (pop),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  // queue is never both full and empty
  a_fifo_stat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.full && stat.empty))
    else $error("queue reports full and empty together");

  // front never pushes into a full queue
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !stat.full)
    else $error("push into full queue");

  // a field streams without gaps once started
  a_no_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !res_o.last) |=> valid_o)
    else $error("gap inside a header field");

  // back end only pops a queue that holds an entry
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

endmodule
